// ===== src/jbsc_pkg.sv =====
// Shared constants and types of the JPEG block symbol coder.
`timescale 1ns / 1ps

package jbsc_pkg;

  localparam int COEFS_PER_BLOCK = 64;
  localparam int NUM_COMPONENTS_DEF = 3;

  localparam int COEF_W = 11;
  localparam int POS_W = 6;
  localparam int COMP_W = 2;
  localparam int SYM_W = 8;
  localparam int AMP_W = 11;
  localparam int LEN_W = 4;
  localparam int RUN_W = 6;
  localparam int RUNS16_W = 2;

  localparam logic [SYM_W-1:0] RUN_SYMBOL = 8'hF0;
  localparam logic [SYM_W-1:0] EOB_SYMBOL = 8'h00;
  localparam logic [RUN_W-1:0] RUN_MAX = 6'd63;

  localparam logic TABLE_DC = 1'b0;
  localparam logic TABLE_AC = 1'b1;

  // Command queue between the classifier and the symbol sequencer.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  // One queued command: some run-of-16 symbols, then one closing symbol.
  typedef struct packed {
    logic [RUNS16_W-1:0] runs;
    logic [SYM_W-1:0]    symbol;
    logic                table_kind;
    logic [AMP_W-1:0]    amplitude;
    logic [LEN_W-1:0]    amplitude_length;
    logic [COMP_W-1:0]   component;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

// ===== src/jbsc_coef_if.sv =====
// Coefficient request channel: valid/ready with one coefficient and its tags.
`timescale 1ns / 1ps

interface jbsc_coef_if;
  logic               valid;
  logic               ready;
  logic signed [10:0] coefficient;
  logic [5:0]         position;
  logic [1:0]         component;
  logic               restart;

  modport source(output valid, coefficient, position, component, restart, input ready);
  modport sink(input valid, coefficient, position, component, restart, output ready);
endinterface

// ===== src/jbsc_sym_if.sv =====
// Symbol request channel: valid/ready with one coded symbol and amplitude bits.
`timescale 1ns / 1ps

interface jbsc_sym_if;
  logic        valid;
  logic        ready;
  logic [7:0]  symbol;
  logic        table_kind;
  logic [10:0] amplitude;
  logic [3:0]  amplitude_length;
  logic [1:0]  out_component;
  logic        last_of_run;

  modport source(output valid, symbol, table_kind, amplitude, amplitude_length,
                 out_component, last_of_run, input ready);
  modport sink(input valid, symbol, table_kind, amplitude, amplitude_length,
               out_component, last_of_run, output ready);
endinterface

// ===== src/jbsc_front.sv =====
// Front end: accepts coefficients, tracks DC predictors and zero runs, builds commands.
`timescale 1ns / 1ps

module jbsc_front #(
  parameter int NUM_COMPONENTS = jbsc_pkg::NUM_COMPONENTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  jbsc_coef_if.sink                coefs,
  input  jbsc_pkg::queue_status_t  qstat,
  output logic                     push,
  output jbsc_pkg::cmd_t           cmd
);
  import jbsc_pkg::*;

  logic signed [COEF_W-1:0] last_dc [NUM_COMPONENTS];
  logic [RUN_W-1:0]         zero_run;

  logic                     accept;
  logic                     is_dc;
  logic                     is_zero;
  logic                     is_last;
  logic signed [COEF_W-1:0] pred;
  logic [COEF_W:0]          value;
  logic [COEF_W:0]          mag_wide;
  logic [COEF_W:0]          amp_raw;
  logic [AMP_W-1:0]         amp_mask;
  logic [LEN_W-1:0]         size;
  logic [RUN_W-1:0]         run_inc;

  function automatic logic [LEN_W-1:0] size_of(input logic [COEF_W-1:0] mag);
    logic [LEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < COEF_W; i++) begin
      if (mag[i]) begin
        n = LEN_W'(i + 1);
      end
    end
    return n;
  endfunction

  assign coefs.ready = !qstat.full;
  assign accept      = coefs.valid && coefs.ready;
  assign is_dc       = coefs.position == '0;
  assign is_zero     = coefs.coefficient == '0;
  assign is_last     = coefs.position == POS_W'(COEFS_PER_BLOCK - 1);
  assign run_inc     = (zero_run < RUN_MAX) ? zero_run + RUN_W'(1) : zero_run;

  // A restart clears every predictor before this DC reads its own.
  always_comb begin
    pred = '0;
    for (int i = 0; i < NUM_COMPONENTS; i++) begin
      if (!coefs.restart && coefs.component == COMP_W'(i)) begin
        pred = last_dc[i];
      end
    end
  end

  always_comb begin
    if (is_dc) begin
      value = {coefs.coefficient[COEF_W-1], coefs.coefficient} - {pred[COEF_W-1], pred};
    end else begin
      value = {coefs.coefficient[COEF_W-1], coefs.coefficient};
    end
    mag_wide = value[COEF_W] ? ((COEF_W+1)'(0) - value) : value;
    amp_raw  = value[COEF_W] ? (value - (COEF_W+1)'(1)) : value;
    size     = size_of(mag_wide[COEF_W-1:0]);
    amp_mask = AMP_W'(((COEF_W+1)'(1) << size) - (COEF_W+1)'(1));
  end

  always_comb begin
    push                 = accept && (is_dc || !is_zero || is_last);
    cmd.component        = coefs.component;
    cmd.runs             = '0;
    cmd.table_kind       = TABLE_AC;
    cmd.amplitude        = amp_raw[AMP_W-1:0] & amp_mask;
    cmd.amplitude_length = size;
    cmd.symbol           = EOB_SYMBOL;
    if (is_dc) begin
      cmd.table_kind = TABLE_DC;
      cmd.symbol     = {4'b0000, size};
    end else if (is_zero) begin
      cmd.amplitude        = '0;
      cmd.amplitude_length = '0;
    end else begin
      cmd.runs   = zero_run[RUN_W-1:4];
      cmd.symbol = {zero_run[3:0], size};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_run <= '0;
      for (int i = 0; i < NUM_COMPONENTS; i++) begin
        last_dc[i] <= '0;
      end
    end else if (accept) begin
      if (is_dc) begin
        zero_run <= '0;
        for (int i = 0; i < NUM_COMPONENTS; i++) begin
          if (coefs.component == COMP_W'(i)) begin
            last_dc[i] <= coefs.coefficient;
          end else if (coefs.restart) begin
            last_dc[i] <= '0;
          end
        end
      end else if (is_zero) begin
        zero_run <= is_last ? '0 : run_inc;
      end else begin
        zero_run <= '0;
      end
    end
  end

endmodule

// ===== src/jbsc_queue.sv =====
// Small command queue that decouples the classifier from the symbol sequencer.
`timescale 1ns / 1ps

module jbsc_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  jbsc_pkg::cmd_t           push_cmd,
  input  logic                     pop,
  output jbsc_pkg::cmd_t           head,
  output jbsc_pkg::queue_status_t  qstat
);
  import jbsc_pkg::*;

  cmd_t                   entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;

  assign head        = entries[rd_ptr];
  assign qstat.empty = count == '0;
  assign qstat.full  = count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QUEUE_PTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QUEUE_PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== src/jbsc_back.sv =====
// Back end: expands each command into run-of-16 symbols and its closing symbol.
`timescale 1ns / 1ps

module jbsc_back (
  input  logic                     clk,
  input  logic                     rst,
  input  jbsc_pkg::cmd_t           head,
  input  jbsc_pkg::queue_status_t  qstat,
  output logic                     pop,
  jbsc_sym_if.source               symbols
);
  import jbsc_pkg::*;

  logic                out_valid;
  logic [RUNS16_W-1:0] runs_done;
  logic                load;
  logic                emit_run;

  // The output register is refilled whenever it is empty or being taken.
  assign load     = !out_valid || symbols.ready;
  assign emit_run = runs_done != head.runs;
  assign pop      = load && !qstat.empty && !emit_run;

  assign symbols.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      runs_done <= '0;
    end else if (load) begin
      out_valid <= !qstat.empty;
      if (!qstat.empty) begin
        runs_done <= emit_run ? runs_done + RUNS16_W'(1) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !qstat.empty) begin
      symbols.out_component <= head.component;
      if (emit_run) begin
        symbols.symbol           <= RUN_SYMBOL;
        symbols.table_kind       <= TABLE_AC;
        symbols.amplitude        <= '0;
        symbols.amplitude_length <= '0;
        symbols.last_of_run      <= 1'b0;
      end else begin
        symbols.symbol           <= head.symbol;
        symbols.table_kind       <= head.table_kind;
        symbols.amplitude        <= head.amplitude;
        symbols.amplitude_length <= head.amplitude_length;
        symbols.last_of_run      <= 1'b1;
      end
    end
  end

  // The run counter never passes the head command's run count.
  assert property (@(posedge clk) disable iff (rst)
    !qstat.empty |-> runs_done <= head.runs)
    else $error("run counter passed the queued run count");

  // Only a run-of-16 symbol may be anything but the last result of a request.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !symbols.last_of_run |->
      symbols.symbol == RUN_SYMBOL && symbols.table_kind == TABLE_AC &&
      symbols.amplitude_length == '0)
    else $error("non-final result is not a run-of-16 symbol");

  // Releasing a command restarts the run counter for the next one.
  assert property (@(posedge clk) disable iff (rst)
    pop |=> runs_done == '0)
    else $error("run counter not cleared after a command was released");

endmodule

// ===== src/jpeg_block_symbol_coder_unit.sv =====
// Top level of the JPEG baseline DC/AC run-length symbol coder.
`timescale 1ns / 1ps

// Usage:
// The coefs channel takes one quantized coefficient per request, in zigzag
// order, with its position, component and restart flag. The symbols channel
// gives the coded symbols: a DC size category or an AC run/size byte, the
// table kind, the amplitude bits and their count, and a flag on the last
// symbol that a request caused. AC zeros cause no symbol, except a zero at
// position 63, which closes the block with an end-of-block symbol.
// Throughput is one coefficient per cycle while the queue is not full. A nonzero
// AC value after a long zero run yields up to three extra 0xF0 symbols, one per
// cycle on the output register while the receiver takes them; a four-entry
// command queue between the classifier and the symbol sequencer absorbs them,
// and coefs.ready drops only when that queue is full. A taken request enters
// the queue, and its first symbol then moves into the output register once
// that register is free.
// When the receiver stalls, the output register holds its symbol, the queue
// fills, and then the input stalls; nothing is lost or repeated.
// Reset (rst, synchronous) clears all DC predictors, the zero run count,
// the queue and the output register. There is no clearing pass.

module jpeg_block_symbol_coder_unit #(
  parameter int NUM_COMPONENTS = jbsc_pkg::NUM_COMPONENTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  jbsc_coef_if.sink  coefs,
  jbsc_sym_if.source symbols
);
  import jbsc_pkg::*;

  // Front to queue: one command per coefficient that yields symbols.
  logic          push;
  cmd_t          push_cmd;
  // Queue to back: head command and fill status.
  cmd_t          head;
  queue_status_t qstat;
  logic          pop;

  // Classifier: DC differences, predictors, zero-run counting.
  jbsc_front #(
    .NUM_COMPONENTS(NUM_COMPONENTS)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .coefs (coefs),
    .qstat (qstat),
    .push  (push),
    .cmd   (push_cmd)
  );

  // Command queue that lets the two halves stall on their own.
  jbsc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  // Symbol sequencer with the output register.
  jbsc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .qstat   (qstat),
    .pop     (pop),
    .symbols (symbols)
  );

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the JPEG block symbol coder: directed table, then random blocks.
`timescale 1ns / 1ps

module testbench;
  import jbsc_pkg::*;

  localparam int CLK_HALF_NS = 6;
  localparam int RESET_CYCLES = 8;
  localparam int TOTAL_ITEMS = 170;
  localparam int ZERO_RUN_CHUNK = 16;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS = 60;
  // Far beyond the slowest legal run: four symbols per item, each behind a long
  // receiver stall, plus the longest sender gap on every item.
  localparam longint TIMEOUT_NS = 2400000;

  // One coded symbol as it leaves the block.
  typedef struct packed {
    logic [SYM_W-1:0]  symbol;
    logic              table_kind;
    logic [AMP_W-1:0]  amplitude;
    logic [LEN_W-1:0]  amplitude_length;
    logic [COMP_W-1:0] component;
    logic              last_of_run;
  } coded_symbol_t;

  // One line of the directed table; count repeats the same request.
  typedef struct {
    logic signed [COEF_W-1:0] coefficient;
    logic [POS_W-1:0]         position;
    logic [COMP_W-1:0]        component;
    logic                     restart;
    int                       count;
    logic                     hand_checked;
    coded_symbol_t            hand_symbol;
  } coef_row_t;

  typedef enum {RX_OPEN, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic clk;
  logic rst;

  jbsc_coef_if coef_ch();
  jbsc_sym_if  sym_ch();

  jpeg_block_symbol_coder_unit dut (
    .clk(clk),
    .rst(rst),
    .coefs(coef_ch),
    .symbols(sym_ch)
  );

  // Predictor state: one DC history per component and the running zero count.
  logic signed [COEF_W-1:0] dc_history[NUM_COMPONENTS_DEF];
  logic [RUN_W-1:0]         zeros_seen;

  coded_symbol_t coded_now[$];
  coded_symbol_t expected_symbols[$];
  coef_row_t     directed_rows[$];

  int failures = 0;
  int items_sent = 0;
  int burst_left = 0;

  initial begin
    clk = 1'b0;
    forever begin
      #CLK_HALF_NS clk = 1'b1;
      #CLK_HALF_NS clk = 1'b0;
    end
  end

  initial begin
    #TIMEOUT_NS;
    $display("Verification failed");
    $finish;
  end

  // Size category: number of bits needed for the magnitude.
  function automatic logic [LEN_W-1:0] size_category(input int value);
    int mag;
    logic [LEN_W-1:0] n;
    mag = (value < 0) ? -value : value;
    n = '0;
    while (mag != 0) begin
      n++;
      mag = mag >> 1;
    end
    return n;
  endfunction

  // Low bits of the value, one's complement when negative.
  function automatic logic [AMP_W-1:0] amplitude_bits(input int value,
                                                      input logic [LEN_W-1:0] nbits);
    int u;
    u = (value < 0) ? value - 1 : value;
    return AMP_W'(u & ((1 << nbits) - 1));
  endfunction

  function automatic void emit(input logic [SYM_W-1:0] symbol, input logic kind,
                               input logic [AMP_W-1:0] amp, input logic [LEN_W-1:0] len,
                               input logic [COMP_W-1:0] comp);
    coded_symbol_t s;
    s.symbol = symbol;
    s.table_kind = kind;
    s.amplitude = amp;
    s.amplitude_length = len;
    s.component = comp;
    s.last_of_run = 1'b0;
    coded_now.push_back(s);
  endfunction

  // Codes one coefficient into coded_now and advances the predictor state.
  function automatic void code_coefficient(input logic signed [COEF_W-1:0] coef,
                                           input logic [POS_W-1:0] pos,
                                           input logic [COMP_W-1:0] comp,
                                           input logic restart);
    int prediction;
    int diff;
    logic [LEN_W-1:0] nbits;
    coded_now.delete();
    if (pos == 0) begin
      prediction = 0;
      if (restart) begin
        foreach (dc_history[i]) dc_history[i] = '0;
      end
      // A component beyond the last one predicts from zero and leaves history alone.
      if (comp < NUM_COMPONENTS_DEF) begin
        prediction = dc_history[comp];
        dc_history[comp] = coef;
      end
      diff = int'(coef) - prediction;
      nbits = size_category(diff);
      emit(SYM_W'(nbits), TABLE_DC, amplitude_bits(diff, nbits), nbits, comp);
      zeros_seen = '0;
    end else if (coef == 0) begin
      if (zeros_seen != RUN_MAX) zeros_seen++;
      if (pos == COEFS_PER_BLOCK - 1) begin
        emit(EOB_SYMBOL, TABLE_AC, '0, '0, comp);
        zeros_seen = '0;
      end
    end else begin
      nbits = size_category(int'(coef));
      while (zeros_seen >= ZERO_RUN_CHUNK) begin
        emit(RUN_SYMBOL, TABLE_AC, '0, '0, comp);
        zeros_seen = zeros_seen - RUN_W'(ZERO_RUN_CHUNK);
      end
      emit({zeros_seen[3:0], nbits}, TABLE_AC, amplitude_bits(int'(coef), nbits), nbits,
           comp);
      zeros_seen = '0;
    end
    if (coded_now.size() > 0) coded_now[$].last_of_run = 1'b1;
  endfunction

  function automatic void add_row(input int coef, input int pos, input int comp,
                                  input bit restart, input int count);
    coef_row_t r;
    r.coefficient = COEF_W'(coef);
    r.position = POS_W'(pos);
    r.component = COMP_W'(comp);
    r.restart = restart;
    r.count = count;
    r.hand_checked = 1'b0;
    r.hand_symbol = '0;
    directed_rows.push_back(r);
  endfunction

  // A row whose single symbol is written out by hand.
  function automatic void add_known(input int coef, input int pos, input int comp,
                                    input bit restart, input logic [SYM_W-1:0] symbol,
                                    input logic kind, input int amp, input int len);
    coef_row_t r;
    r.coefficient = COEF_W'(coef);
    r.position = POS_W'(pos);
    r.component = COMP_W'(comp);
    r.restart = restart;
    r.count = 1;
    r.hand_checked = 1'b1;
    r.hand_symbol.symbol = symbol;
    r.hand_symbol.table_kind = kind;
    r.hand_symbol.amplitude = AMP_W'(amp);
    r.hand_symbol.amplitude_length = LEN_W'(len);
    r.hand_symbol.component = COMP_W'(comp);
    r.hand_symbol.last_of_run = 1'b1;
    directed_rows.push_back(r);
  endfunction

  // Presents one request, with bursty gaps, and records its symbols once taken.
  task automatic send_request(input logic signed [COEF_W-1:0] coef,
                              input logic [POS_W-1:0] pos, input logic [COMP_W-1:0] comp,
                              input logic restart, input bit hand_checked,
                              input coded_symbol_t hand_symbol);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        coef_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    coef_ch.valid <= 1'b1;
    coef_ch.coefficient <= coef;
    coef_ch.position <= pos;
    coef_ch.component <= comp;
    coef_ch.restart <= restart;
    do @(posedge clk); while (!coef_ch.ready);
    items_sent++;
    code_coefficient(coef, pos, comp, restart);
    if (hand_checked) begin
      expected_symbols.push_back(hand_symbol);
    end else begin
      foreach (coded_now[i]) expected_symbols.push_back(coded_now[i]);
    end
  endtask

  task automatic send_coef(input logic signed [COEF_W-1:0] coef, input int pos,
                           input logic [COMP_W-1:0] comp, input logic restart);
    send_request(coef, POS_W'(pos), comp, restart, 1'b0, '0);
  endtask

  // Holds the sender off until every symbol owed has come out.
  task automatic drain_symbols();
    coef_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_symbols.size() != 0);
    burst_left = 0;
  endtask

  // Nonzero coefficient with a random size category, extremes now and then.
  function automatic logic signed [COEF_W-1:0] random_nonzero();
    int sz;
    int mag;
    bit negative;
    case ($urandom_range(0, 11))
      // Most negative value, -1024.
      0: return 11'sh400;
      1: return 11'sd1023;
      2: return -11'sd1;
      3: return 11'sd1;
      default: begin
        sz = $urandom_range(1, 11);
        mag = $urandom_range(1 << (sz - 1), (1 << sz) - 1);
        negative = $urandom_range(0, 1);
        if (negative && mag > 1024) mag = 1024;
        if (!negative && mag > 1023) mag = 1023;
        return COEF_W'(negative ? -mag : mag);
      end
    endcase
  endfunction

  // A well-formed block: DC, a stretch of AC items, closed at position 63.
  task automatic send_block();
    logic [COMP_W-1:0] comp;
    logic restart;
    int ac_items;
    int zero_pct;
    int room;
    comp = ($urandom_range(0, 9) == 0) ? COMP_W'(3) : COMP_W'($urandom_range(0, 2));
    restart = ($urandom_range(0, 7) == 0);
    send_coef(($urandom_range(0, 5) == 0) ? '0 : random_nonzero(), 0, comp, restart);
    ac_items = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 62) : $urandom_range(1, 10);
    // Keep the block inside the item budget; it still closes at position 63.
    room = TOTAL_ITEMS - items_sent - 1;
    if (ac_items > room) ac_items = (room > 1) ? room : 1;
    zero_pct = $urandom_range(30, 95);
    for (int p = 1; p <= ac_items; p++) begin
      send_coef(($urandom_range(0, 99) < zero_pct) ? '0 : random_nonzero(), p, comp,
                1'($urandom_range(0, 1)));
    end
    send_coef(($urandom_range(0, 1) == 0) ? '0 : random_nonzero(), COEFS_PER_BLOCK - 1,
              comp, 1'($urandom_range(0, 1)));
  endtask

  // Receiver: switches among randomly chosen stall patterns.
  initial begin : receiver
    rx_mode_t mode;
    int unsigned tick;
    mode = RX_OPEN;
    tick = 0;
    sym_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (tick % 32 == 0) mode = rx_mode_t'($urandom_range(0, 3));
      tick++;
      case (mode)
        RX_OPEN: sym_ch.ready <= 1'b1;
        RX_HALF: sym_ch.ready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: sym_ch.ready <= ($urandom_range(0, 3) == 0);
        default: sym_ch.ready <= ((tick % 7) >= 3);
      endcase
    end
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      failures++;
      if (failures <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  // Each symbol taken from the block is matched against the oldest one owed.
  always @(posedge clk) begin
    coded_symbol_t want;
    if (!rst && sym_ch.valid && sym_ch.ready) begin
      if (expected_symbols.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t: unexpected symbol, expected none, actual 0x%0h", $time,
                   sym_ch.symbol);
      end else begin
        want = expected_symbols.pop_front();
        check_field("symbol", want.symbol, sym_ch.symbol);
        check_field("table_kind", want.table_kind, sym_ch.table_kind);
        check_field("amplitude", want.amplitude, sym_ch.amplitude);
        check_field("amplitude_length", want.amplitude_length, sym_ch.amplitude_length);
        check_field("out_component", want.component, sym_ch.out_component);
        check_field("last_of_run", want.last_of_run, sym_ch.last_of_run);
      end
    end
  end

  initial begin : stimulus
    bit paused;
    int half_mark;
    foreach (dc_history[i]) dc_history[i] = '0;
    zeros_seen = '0;
    paused = 1'b0;
    rst <= 1'b1;
    coef_ch.valid <= 1'b0;
    coef_ch.coefficient <= '0;
    coef_ch.position <= '0;
    coef_ch.component <= '0;
    coef_ch.restart <= 1'b0;

    // DC extremes from reset, including the widest possible difference.
    add_known(0, 0, 0, 0, 8'd0, TABLE_DC, 0, 0);
    add_known(1023, 0, 1, 0, 8'd10, TABLE_DC, 'h3FF, 10);
    add_known(-1024, 0, 2, 0, 8'd11, TABLE_DC, 'h3FF, 11);
    add_known(-1024, 0, 1, 0, 8'd11, TABLE_DC, 'h000, 11);
    // AC values of both signs, size eleven, and a restart flag on an AC item.
    add_row(0, 1, 1, 0, 1);
    add_row(1, 2, 1, 0, 1);
    add_row(-1, 3, 1, 0, 1);
    add_row(-1024, 4, 1, 1, 1);
    add_row(1023, 5, 1, 0, 1);
    // Exactly sixteen zeros, then a long run closed by end of block.
    add_row(0, 6, 1, 0, 16);
    add_row(5, 22, 1, 0, 1);
    add_row(0, 23, 1, 0, 20);
    add_known(0, 63, 1, 0, EOB_SYMBOL, TABLE_AC, 0, 0);
    // Zero count saturates when items come out of order; nonzero AC at 63.
    add_row(0, 1, 3, 0, 70);
    add_row(-3, 10, 3, 0, 1);
    add_row(7, 63, 3, 0, 1);
    // Out-of-range component, then a restart clearing every predictor.
    add_known(100, 0, 3, 0, 8'd7, TABLE_DC, 100, 7);
    add_known(-5, 0, 0, 1, 8'd3, TABLE_DC, 2, 3);
    add_known(0, 0, 1, 0, 8'd0, TABLE_DC, 0, 0);
    add_known(0, 63, 1, 0, EOB_SYMBOL, TABLE_AC, 0, 0);
    // A DC item drops whatever zero run came before it.
    add_row(0, 7, 2, 0, 5);
    add_row(1, 0, 2, 0, 1);
    add_row(1, 1, 2, 0, 1);
    add_known(0, 63, 2, 0, EOB_SYMBOL, TABLE_AC, 0, 0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].count; k++) begin
        send_request(directed_rows[r].coefficient, directed_rows[r].position,
                     directed_rows[r].component, directed_rows[r].restart,
                     directed_rows[r].hand_checked, directed_rows[r].hand_symbol);
      end
    end
    drain_symbols();

    // Random part: mostly whole blocks, with stray requests mixed in.
    half_mark = items_sent + (TOTAL_ITEMS - items_sent) / 2;
    while (items_sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        send_coef(($urandom_range(0, 3) == 0) ? '0 : random_nonzero(),
                  $urandom_range(0, 63), COMP_W'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)));
      end else begin
        send_block();
      end
      if (!paused && items_sent >= half_mark) begin
        drain_symbols();
        paused = 1'b1;
      end
    end

    coef_ch.valid <= 1'b0;
    while (expected_symbols.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
